[src/mpfb_pkg.sv]
// Package for the monochrome page framebuffer draw block.
// Holds screen geometry constants, request and colour codes, payload structs and helpers.
// No dependencies.
package mpfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int MAX_DIM       = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int LEN_W         = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    REQ_PIXEL = 3'd0,
    REQ_HLINE = 3'd1,
    REQ_VLINE = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    COLOR_BLACK   = 2'd0,
    COLOR_WHITE   = 2'd1,
    COLOR_INVERSE = 2'd2,
    COLOR_NONE    = 2'd3
  } color_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_CLIP,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
    logic signed [15:0]  span;
    logic [1:0]          color;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       wrote_any;
  } out_t;

  typedef struct packed {
    logic              vld;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic [1:0]        color;
  } op_t;

  function automatic logic [7:0] apply_color(logic [7:0] data, logic [7:0] mask,
                                             logic [1:0] color);
    logic [7:0] res;
    res = data;
    case (color)
      COLOR_BLACK:   res = data & ~mask;
      COLOR_WHITE:   res = data | mask;
      COLOR_INVERSE: res = data ^ mask;
      default:       res = data;
    endcase
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(logic [PAGE_W-1:0] page);
    logic [31:0] pw;
    pw = 32'(page);
    return ADDR_W'(pw * 32'(SCREEN_WIDTH));
  endfunction

endpackage

[src/mpfb_rmw.sv]
// Read-modify-write unit with the framebuffer memory.
// Applies one masked colour operation per cycle; uses mpfb_pkg.
// Read data is registered, and the write lands in the cycle after the read.
module mpfb_rmw (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mpfb_pkg::op_t  op_i,
  output logic [7:0]     rdata_o
);

  logic [7:0]    mem [mpfb_pkg::STORE_SIZE];
  logic [7:0]    rdata_q;
  mpfb_pkg::op_t op_q;
  logic          op_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q <= 1'b0;
    end else begin
      op_vld_q <= op_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_i;
    if (op_i.vld) begin
      rdata_q <= mem[op_i.addr];
    end
    if (op_vld_q && op_q.wr) begin
      mem[op_q.addr] <= mpfb_pkg::apply_color(rdata_q, op_q.mask, op_q.color);
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mpfb_ctrl.sv]
// Sequencer for the framebuffer draw block: clipping, address stepping and the result register.
// Drives the read-modify-write unit one byte per cycle; uses mpfb_pkg.
module mpfb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mpfb_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mpfb_pkg::out_t  out_data_o,
  output mpfb_pkg::op_t   op_o,
  input  logic [7:0]      rdata_i
);

  mpfb_pkg::state_e state_q, state_d;

  logic signed [15:0]              mov_q, mov_d;
  logic signed [15:0]              fix_q, fix_d;
  logic signed [15:0]              span_q, span_d;
  logic signed [16:0]              end_q, end_d;
  logic [mpfb_pkg::LEN_W-1:0]      start_q, start_d;
  logic [mpfb_pkg::LEN_W-1:0]      endc_q, endc_d;
  logic [mpfb_pkg::ADDR_W-1:0]     addr_q, addr_d;
  logic [mpfb_pkg::ADDR_W-1:0]     cnt_q, cnt_d;
  logic                            first_q, first_d;
  logic [7:0]                      base_q, base_d;
  logic [7:0]                      head_q, head_d;
  logic [7:0]                      tail_q, tail_d;
  logic                            vert_q, vert_d;
  logic                            read_q, read_d;
  logic                            boot_q, boot_d;
  logic [1:0]                      color_q, color_d;
  logic                            wrote_q, wrote_d;
  logic [7:0]                      rd_q, rd_d;
  logic                            out_vld_q, out_vld_d;
  mpfb_pkg::out_t                  out_q, out_d;

  logic signed [17:0]              st_s, en_s, lim_s;
  logic [14:0]                     lim_fix;
  logic                            fix_ok;
  logic [mpfb_pkg::LEN_W-1:0]      last_l;
  logic [mpfb_pkg::PAGE_W-1:0]     ps, pe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mpfb_pkg::ST_CLEAR;
      addr_q    <= '0;
      cnt_q     <= mpfb_pkg::ADDR_W'(mpfb_pkg::STORE_SIZE - 1);
      boot_q    <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      cnt_q     <= cnt_d;
      boot_q    <= boot_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mov_q   <= mov_d;
    fix_q   <= fix_d;
    span_q  <= span_d;
    end_q   <= end_d;
    start_q <= start_d;
    endc_q  <= endc_d;
    first_q <= first_d;
    base_q  <= base_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    vert_q  <= vert_d;
    read_q  <= read_d;
    color_q <= color_d;
    wrote_q <= wrote_d;
    rd_q    <= rd_d;
    out_q   <= out_d;
  end

  always_comb begin
    st_s    = mov_q[15] ? 18'sd0 : $signed({2'b00, mov_q});
    lim_s   = vert_q ? 18'(mpfb_pkg::SCREEN_HEIGHT) : 18'(mpfb_pkg::SCREEN_WIDTH);
    en_s    = $signed({end_q[16], end_q});
    if (en_s > lim_s) begin
      en_s = lim_s;
    end
    lim_fix = vert_q ? 15'(mpfb_pkg::SCREEN_WIDTH) : 15'(mpfb_pkg::SCREEN_HEIGHT);
    fix_ok  = !fix_q[15] && (fix_q[14:0] < lim_fix);
    last_l  = endc_q - mpfb_pkg::LEN_W'(1);
    ps      = mpfb_pkg::PAGE_W'(start_q >> 3);
    pe      = mpfb_pkg::PAGE_W'(last_l >> 3);
  end

  always_comb begin
    state_d   = state_q;
    mov_d     = mov_q;
    fix_d     = fix_q;
    span_d    = span_q;
    end_d     = end_q;
    start_d   = start_q;
    endc_d    = endc_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    base_d    = base_q;
    head_d    = head_q;
    tail_d    = tail_q;
    vert_d    = vert_q;
    read_d    = read_q;
    boot_d    = boot_q;
    color_d   = color_q;
    wrote_d   = wrote_q;
    rd_d      = rd_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    op_o      = '0;
    op_o.addr = addr_q;

    case (state_q)
      mpfb_pkg::ST_CLEAR: begin
        op_o.vld   = 1'b1;
        op_o.wr    = 1'b1;
        op_o.mask  = 8'hFF;
        op_o.color = mpfb_pkg::COLOR_BLACK;
        if (cnt_q == '0) begin
          state_d = boot_q ? mpfb_pkg::ST_IDLE : mpfb_pkg::ST_DRAIN;
          boot_d  = 1'b0;
        end else begin
          addr_d = addr_q + mpfb_pkg::ADDR_W'(1);
          cnt_d  = cnt_q - mpfb_pkg::ADDR_W'(1);
        end
      end
      mpfb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          wrote_d = 1'b0;
          rd_d    = '0;
          color_d = in_data_i.color;
          vert_d  = 1'b0;
          read_d  = 1'b0;
          mov_d   = in_data_i.x;
          fix_d   = in_data_i.y;
          span_d  = 16'sd1;
          case (in_data_i.req_type)
            mpfb_pkg::REQ_PIXEL: begin
              state_d = mpfb_pkg::ST_SPAN;
            end
            mpfb_pkg::REQ_HLINE: begin
              span_d  = in_data_i.span;
              state_d = mpfb_pkg::ST_SPAN;
            end
            mpfb_pkg::REQ_VLINE: begin
              mov_d   = in_data_i.y;
              fix_d   = in_data_i.x;
              span_d  = in_data_i.span;
              vert_d  = 1'b1;
              state_d = mpfb_pkg::ST_SPAN;
            end
            mpfb_pkg::REQ_READ: begin
              read_d  = 1'b1;
              state_d = mpfb_pkg::ST_SPAN;
            end
            mpfb_pkg::REQ_CLEAR: begin
              addr_d  = '0;
              cnt_d   = mpfb_pkg::ADDR_W'(mpfb_pkg::STORE_SIZE - 1);
              wrote_d = 1'b1;
              state_d = mpfb_pkg::ST_CLEAR;
            end
            default: begin
              state_d = mpfb_pkg::ST_DONE;
            end
          endcase
        end
      end
      mpfb_pkg::ST_SPAN: begin
        end_d   = {mov_q[15], mov_q} + {span_q[15], span_q};
        state_d = mpfb_pkg::ST_CLIP;
      end
      mpfb_pkg::ST_CLIP: begin
        start_d = mpfb_pkg::LEN_W'(st_s);
        endc_d  = mpfb_pkg::LEN_W'(en_s);
        if (fix_ok && (en_s > st_s) && (read_q || (color_q != mpfb_pkg::COLOR_NONE))) begin
          state_d = mpfb_pkg::ST_SETUP;
        end else begin
          state_d = mpfb_pkg::ST_DONE;
        end
      end
      mpfb_pkg::ST_SETUP: begin
        first_d = 1'b1;
        if (vert_q) begin
          addr_d = mpfb_pkg::page_addr(ps) + mpfb_pkg::ADDR_W'(fix_q[14:0]);
          cnt_d  = mpfb_pkg::ADDR_W'(pe - ps);
          base_d = 8'hFF;
          head_d = 8'hFF << start_q[2:0];
          tail_d = 8'hFF >> (3'd7 - last_l[2:0]);
        end else begin
          addr_d = mpfb_pkg::page_addr(mpfb_pkg::PAGE_W'(fix_q[15:3]))
                   + mpfb_pkg::ADDR_W'(start_q);
          cnt_d  = mpfb_pkg::ADDR_W'(last_l - start_q);
          base_d = 8'h01 << fix_q[2:0];
          head_d = 8'hFF;
          tail_d = 8'hFF;
        end
        state_d = mpfb_pkg::ST_RUN;
      end
      mpfb_pkg::ST_RUN: begin
        op_o.vld   = 1'b1;
        op_o.wr    = !read_q;
        op_o.color = color_q;
        op_o.mask  = base_q & (first_q ? head_q : 8'hFF) & ((cnt_q == '0) ? tail_q : 8'hFF);
        wrote_d    = !read_q;
        first_d    = 1'b0;
        if (cnt_q == '0) begin
          state_d = mpfb_pkg::ST_DRAIN;
        end else begin
          cnt_d  = cnt_q - mpfb_pkg::ADDR_W'(1);
          addr_d = addr_q + (vert_q ? mpfb_pkg::ADDR_W'(mpfb_pkg::SCREEN_WIDTH)
                                    : mpfb_pkg::ADDR_W'(1));
        end
      end
      mpfb_pkg::ST_DRAIN: begin
        rd_d    = read_q ? rdata_i : 8'h00;
        state_d = mpfb_pkg::ST_DONE;
      end
      mpfb_pkg::ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d.read_data = rd_q;
          out_d.wrote_any = wrote_q;
          out_vld_d       = 1'b1;
          state_d         = mpfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpfb_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != mpfb_pkg::ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[src/mono_page_framebuffer_draw_top.sv]
// Monochrome page framebuffer with pixel and line drawing, 1 bit per pixel in 8-row pages.
// A request steps SPAN, CLIP, SETUP, RUN (once per byte of a line), DRAIN, DONE; a clear runs
// CLEAR over all STORE_SIZE (1024) bytes, then DRAIN and DONE. One request is taken at a time;
// a clipped or colourless draw jumps from CLIP to DONE, an unknown type from IDLE to DONE.
// Reset: asynchronous, active low; afterwards a clearing pass over all STORE_SIZE (1024) bytes
// zeroes the memory while input stays stalled. Depends on mpfb_pkg, mpfb_ctrl and mpfb_rmw.
module mono_page_framebuffer_draw_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mpfb_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mpfb_pkg::out_t  out_data_o
);

  mpfb_pkg::op_t op;
  logic [7:0]    rdata;

  mpfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .op_o        (op),
    .rdata_i     (rdata)
  );

  mpfb_rmw u_rmw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .rdata_o (rdata)
  );

endmodule
